>>> hw/rtl/gep_pkg.sv
// shared types, constants and helpers for the glyph bitmap pixel expander
`timescale 1ns / 1ps

package gep_pkg;

  localparam int MAX_GLYPH_SIZE = 64;
  localparam int RUN_FIELD_MAX  = 127;
  localparam int SIZE_LIMIT     = (MAX_GLYPH_SIZE < RUN_FIELD_MAX) ? MAX_GLYPH_SIZE
                                                                   : RUN_FIELD_MAX;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BG_COLOR = 1'b1;

  typedef logic [6:0]  dim_t;
  typedef logic [15:0] color_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } item_kind_t;

  // where the back end stands within the current bitmap bit
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_PIXEL = 2'd1,
    PH_TRAIL = 2'd2
  } bit_phase_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  bits;
    dim_t        width;
    dim_t        height;
    dim_t        lpad;
    dim_t        rpad;
  } glyph_cmd_t;

  function automatic dim_t clamp_dim(logic signed [9:0] v);
    dim_t r;
    if (v <= 10'sd0) begin
      r = '0;
    end else if (v > $signed(10'(SIZE_LIMIT))) begin
      r = 7'(SIZE_LIMIT);
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/gep_front.sv
// front end: accepts items and turns start geometry into clamped run lengths
`timescale 1ns / 1ps

module gep_front import gep_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [7:0]        bitmap_byte,
  input  logic [6:0]        glyph_width,
  input  logic [6:0]        glyph_height,
  input  logic signed [7:0] x_offset,
  input  logic [6:0]        advance,
  input  logic              q_full,
  output logic              push,
  output glyph_cmd_t        cmd
);

  logic signed [9:0] xoff_ext;
  logic signed [9:0] right_raw;
  dim_t              width_c;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign xoff_ext = {{2{x_offset[7]}}, x_offset};
  assign width_c  = clamp_dim($signed({3'b000, glyph_width}));
  // right padding uses the raw signed offset, not the clamped left padding
  assign right_raw = $signed({3'b000, advance}) - ($signed({3'b000, width_c}) + xoff_ext);

  always_comb begin
    cmd.kind   = item_kind_t'(kind);
    cmd.bits   = bitmap_byte;
    cmd.width  = width_c;
    cmd.height = clamp_dim($signed({3'b000, glyph_height}));
    cmd.lpad   = clamp_dim(xoff_ext);
    cmd.rpad   = clamp_dim(right_raw);
  end

endmodule

>>> hw/rtl/gep_queue.sv
// short item queue between the front end and the back end
`timescale 1ns / 1ps

module gep_queue import gep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  glyph_cmd_t push_cmd,
  input  logic       pop,
  output glyph_cmd_t head,
  output logic       head_valid,
  output logic       full
);

  glyph_cmd_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/gep_back.sv
// back end: walks the bitmap bits and emits one pixel or padding run a cycle unless stalled or out of items
`timescale 1ns / 1ps

module gep_back import gep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  glyph_cmd_t head,
  input  logic       head_valid,
  output logic       pop,
  input  color_t     fg_color,
  input  color_t     bg_color,
  output logic       out_valid,
  input  logic       out_stall,
  output color_t     pixel_color,
  output logic [6:0] run_length,
  output logic       row_end,
  output logic       glyph_done
);

  dim_t       width_held, height_held, left_pad_held, right_pad_held;
  dim_t       column_count, row_count;
  logic       glyph_active;
  logic [2:0] bit_idx;
  bit_phase_t phase;

  dim_t       width_held_next, height_held_next, left_pad_held_next, right_pad_held_next;
  dim_t       column_count_next, row_count_next;
  logic       glyph_active_next;
  logic [2:0] bit_idx_next;
  bit_phase_t phase_next;

  logic       out_space, go, emit, advance_bit, finish_row;
  logic       last_col, last_row;
  dim_t       col_inc, row_inc;
  color_t     bit_color, e_color;
  logic [6:0] e_len;
  logic       e_row_end, e_done;

  assign out_space = !out_valid || !out_stall;
  assign go        = head_valid && out_space;
  assign col_inc   = column_count + 7'd1;
  assign row_inc   = row_count + 7'd1;
  assign last_col  = (col_inc >= width_held);
  assign last_row  = (row_inc >= height_held);
  // msb first
  assign bit_color = head.bits[~bit_idx] ? fg_color : bg_color;

  always_comb begin
    width_held_next     = width_held;
    height_held_next    = height_held;
    left_pad_held_next  = left_pad_held;
    right_pad_held_next = right_pad_held;
    column_count_next   = column_count;
    row_count_next      = row_count;
    glyph_active_next   = glyph_active;
    bit_idx_next        = bit_idx;
    phase_next          = phase;
    pop                 = 1'b0;
    emit                = 1'b0;
    advance_bit         = 1'b0;
    finish_row          = 1'b0;
    e_color             = bg_color;
    e_len               = 7'd1;
    e_row_end           = 1'b0;
    e_done              = 1'b0;

    if (go) begin
      if (head.kind == KIND_START) begin
        width_held_next     = head.width;
        height_held_next    = head.height;
        left_pad_held_next  = head.lpad;
        right_pad_held_next = head.rpad;
        column_count_next   = '0;
        row_count_next      = '0;
        glyph_active_next   = (head.width != '0) && (head.height != '0);
        bit_idx_next        = '0;
        phase_next          = PH_LEAD;
        pop                 = 1'b1;
      end else if (!glyph_active) begin
        // byte with no glyph open is dropped
        bit_idx_next = '0;
        phase_next   = PH_LEAD;
        pop          = 1'b1;
      end else if (phase == PH_LEAD && column_count == '0 && left_pad_held != '0) begin
        emit       = 1'b1;
        e_color    = bg_color;
        e_len      = left_pad_held;
        phase_next = PH_PIXEL;
      end else if (phase == PH_TRAIL) begin
        emit        = 1'b1;
        e_color     = bg_color;
        e_len       = right_pad_held;
        e_row_end   = 1'b1;
        e_done      = last_row;
        advance_bit = 1'b1;
        finish_row  = 1'b1;
      end else if (!last_col) begin
        emit              = 1'b1;
        e_color           = bit_color;
        column_count_next = col_inc;
        advance_bit       = 1'b1;
      end else if (right_pad_held != '0) begin
        emit       = 1'b1;
        e_color    = bit_color;
        phase_next = PH_TRAIL;
      end else begin
        emit        = 1'b1;
        e_color     = bit_color;
        e_row_end   = 1'b1;
        e_done      = last_row;
        advance_bit = 1'b1;
        finish_row  = 1'b1;
      end

      if (finish_row) begin
        column_count_next = '0;
        if (last_row) begin
          glyph_active_next = 1'b0;
          row_count_next    = '0;
        end else begin
          row_count_next = row_inc;
        end
      end

      if (advance_bit) begin
        phase_next   = PH_LEAD;
        bit_idx_next = bit_idx + 3'd1;
        // leftover bits after the last row are dropped with the byte
        if (bit_idx == 3'd7 || (finish_row && last_row)) begin
          bit_idx_next = '0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_held     <= '0;
      height_held    <= '0;
      left_pad_held  <= '0;
      right_pad_held <= '0;
      column_count   <= '0;
      row_count      <= '0;
      glyph_active   <= 1'b0;
      bit_idx        <= '0;
      phase          <= PH_LEAD;
      out_valid      <= 1'b0;
    end else begin
      width_held     <= width_held_next;
      height_held    <= height_held_next;
      left_pad_held  <= left_pad_held_next;
      right_pad_held <= right_pad_held_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      glyph_active   <= glyph_active_next;
      bit_idx        <= bit_idx_next;
      phase          <= phase_next;
      if (out_space) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_color <= e_color;
      run_length  <= e_len;
      row_end     <= e_row_end;
      glyph_done  <= e_done;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && glyph_done |-> row_end)
    else $error("glyph_done without row_end");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length != '0)
    else $error("zero length run emitted");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    glyph_active |-> column_count < width_held)
    else $error("column count past glyph width");

  a_trail_needs_pad: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> glyph_active && right_pad_held != '0)
    else $error("right padding phase without padding");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/glyph_bitmap_pixel_expander_top.sv
// Glyph bitmap pixel expander: input item channel in, pixel run channel out.
// A kind 0 item loads glyph geometry (width, height, x offset, advance); kind 1
// items carry bitmap bytes, read msb first, running on across rows. Each
// result is a colour and a run length: bitmap pixels come out one at a time,
// left and right padding as single background runs, with row_end on the last
// result of a row and glyph_done on the last of the glyph.
// An item is taken when in_valid is high and in_stall low; a result is taken
// when out_valid is high and out_stall low. Four items queue between the
// input and the bit walker, so input keeps flowing while results wait.
// With the queue empty, a taken byte is queued and its result then registered at
// the output. Throughput: the bit walker gives one result per cycle while the queue
// holds an item and the output is not stalled; a byte yields up to 24 results, a
// start item or ignored byte none. A stalled output holds its result and pauses the
// walker; the queue then fills and raises in_stall. Reset (synchronous, rst high)
// empties the queue and the output, closes any glyph and sets fg_color to 0xffff,
// bg_color to 0. The user writes the colours over the APB port at byte address 0
// (fg_color) and 4 (bg_color) only while idle; the block does not enforce this.
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander_top import gep_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [7:0]        bitmap_byte,
  input  logic [6:0]        glyph_width,
  input  logic [6:0]        glyph_height,
  input  logic signed [7:0] x_offset,
  input  logic [6:0]        advance,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       pixel_color,
  output logic [6:0]        run_length,
  output logic              row_end,
  output logic              glyph_done
);

  color_t     fg_color, bg_color;
  logic       push, pop, q_full, head_valid;
  glyph_cmd_t push_cmd, head;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_BG_COLOR) ? {16'h0000, bg_color} : {16'h0000, fg_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 16'hffff;
      bg_color <= 16'h0000;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_FG_COLOR) begin
        fg_color <= pwdata[15:0];
      end else begin
        bg_color <= pwdata[15:0];
      end
    end
  end

  gep_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .bitmap_byte  (bitmap_byte),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .x_offset     (x_offset),
    .advance      (advance),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  gep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  gep_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_color (pixel_color),
    .run_length  (run_length),
    .row_end     (row_end),
    .glyph_done  (glyph_done)
  );

endmodule
